// File: hw/rtl/ldq_pkg.sv
package ldq_pkg;

    // Fixed formats of the line and coefficient fields.
    localparam int COORD_W    = 32;
    localparam int CFRAC      = COORD_W / 2;
    localparam int COEF_W     = 64;
    localparam int COEF_FRAC  = 32;
    localparam int VFRAC      = 30;
    localparam int UFRAC      = 60;

    // Pipeline geometry.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 33;
    localparam int NUM_MUL    = 21;
    localparam int MUL_STAGES = 4;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // Line after the front: origin, direction magnitudes and signs.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] o;
        logic [2:0][COORD_W:0]   mag;
        logic [2:0]              neg;
        logic                    degen;
    } ldq_item_t;

    // Line after normalization: origin and unit direction in Q2.30.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] o;
        logic [2:0][31:0]        v;
        logic                    degen;
    } ldq_vec_t;

endpackage

// File: hw/rtl/ldq_front.sv
module ldq_front
    import ldq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] origin_z,
    input  logic signed [COORD_W-1:0] through_x,
    input  logic signed [COORD_W-1:0] through_y,
    input  logic signed [COORD_W-1:0] through_z,
    input  logic                      q_full,
    output logic                      push,
    output ldq_item_t                 item
);

    logic      f_v_reg;
    ldq_item_t f_item_reg;
    ldq_item_t f_item_next;

    logic signed [COORD_W-1:0] o_in [3];
    logic signed [COORD_W-1:0] t_in [3];
    logic signed [COORD_W:0]   d    [3];

    assign o_in[0] = origin_x;
    assign o_in[1] = origin_y;
    assign o_in[2] = origin_z;
    assign t_in[0] = through_x;
    assign t_in[1] = through_y;
    assign t_in[2] = through_z;

    // Direction, its magnitudes and signs, and the coincident-point flag.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i] = (COORD_W + 1)'(t_in[i]) - (COORD_W + 1)'(o_in[i]);
            f_item_next.o[i]   = o_in[i];
            f_item_next.neg[i] = d[i][COORD_W];
            f_item_next.mag[i] = d[i][COORD_W] ? (COORD_W + 1)'(-d[i]) : d[i];
        end
        f_item_next.degen = (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
    end

    // A valid line in the input register holds while the queue is full.
    assign in_stall = f_v_reg && q_full;
    assign push     = f_v_reg && !q_full;
    assign item     = f_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            f_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

// File: hw/rtl/ldq_queue.sv
module ldq_queue
    import ldq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ldq_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output ldq_item_t head
);

    ldq_item_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_reg;
    logic [Q_PTR_W-1:0]   rd_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic [Q_CNT_W-1:0]   cnt_next;
    logic                 do_pop;

    assign full   = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = mem_reg[rd_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/ldq_norm.sv
module ldq_norm
    import ldq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  ldq_item_t in_item,
    output logic      out_valid,
    output ldq_vec_t  out_vec
);

    typedef struct packed {
        logic [2:0][30:0]        m;
        logic [2:0][COORD_W-1:0] o;
        logic [2:0]              neg;
        logic                    degen;
    } side_t;

    // Front stages: maximum, leading-one position, shift, squares, sum.
    logic        s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    ldq_item_t   s1_item_reg, s2_item_reg;
    logic [COORD_W:0] s1_mx_reg;
    logic [5:0]  s2_pos_reg;
    side_t       s3_side_reg, s4_side_reg, s5_side_reg;
    logic [61:0] s4_sq_reg [3];
    logic [63:0] s5_s_reg;

    logic [COORD_W:0] mx_next;
    logic [5:0]       pos_next;
    side_t            side_next;
    logic [COORD_W:0] sh;

    always_comb
    begin
        mx_next = in_item.mag[0];
        if (in_item.mag[1] > mx_next)
        begin
            mx_next = in_item.mag[1];
        end
        if (in_item.mag[2] > mx_next)
        begin
            mx_next = in_item.mag[2];
        end
    end

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i <= COORD_W; i++)
        begin
            if (s1_mx_reg[i])
            begin
                pos_next = 6'(i);
            end
        end
    end

    // Bring the largest magnitude into [2^30, 2^31).
    always_comb
    begin
        sh = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (s2_pos_reg > 6'd30)
            begin
                sh = s2_item_reg.mag[i] >> (s2_pos_reg - 6'd30);
            end
            else
            begin
                sh = s2_item_reg.mag[i] << (6'd30 - s2_pos_reg);
            end
            side_next.m[i] = sh[30:0];
        end
        side_next.o     = s2_item_reg.o;
        side_next.neg   = s2_item_reg.neg;
        side_next.degen = s2_item_reg.degen;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= in_item;
            s1_mx_reg   <= mx_next;
            s2_item_reg <= s1_item_reg;
            s2_pos_reg  <= pos_next;
            s3_side_reg <= side_next;
            s4_side_reg <= s3_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_sq_reg[i] <= 62'(s3_side_reg.m[i]) * 62'(s3_side_reg.m[i]);
            end
            s5_side_reg <= s4_side_reg;
            s5_s_reg    <= 64'(s4_sq_reg[0]) + 64'(s4_sq_reg[1]) + 64'(s4_sq_reg[2]);
        end
    end

    // Square root, two radicand bits per stage.
    logic        sq_v_reg    [SQRT_STEPS];
    logic [34:0] sq_rem_reg  [SQRT_STEPS];
    logic [31:0] sq_root_reg [SQRT_STEPS];
    logic [63:0] sq_s_reg    [SQRT_STEPS];
    side_t       sq_side_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [34:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] s_in;
        side_t       side_in;
        logic [34:0] x;
        logic [34:0] t;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = s5_s_reg;
            assign side_in = s5_side_reg;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign s_in    = sq_s_reg[k-1];
            assign side_in = sq_side_reg[k-1];
        end

        always_comb
        begin
            x = {rem_in[32:0], s_in[63-2*k], s_in[62-2*k]};
            t = {1'b0, root_in, 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (x >= t)
                begin
                    sq_rem_reg[k]  <= x - t;
                    sq_root_reg[k] <= {root_in[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[k]  <= x;
                    sq_root_reg[k] <= {root_in[30:0], 1'b0};
                end
                sq_s_reg[k]    <= s_in;
                sq_side_reg[k] <= side_in;
            end
        end
    end

    // Reciprocal 2^62 / r, one quotient bit per stage.
    logic        dv_v_reg    [DIV_STEPS];
    logic [31:0] dv_rem_reg  [DIV_STEPS];
    logic [31:0] dv_r_reg    [DIV_STEPS];
    logic [32:0] dv_q_reg    [DIV_STEPS];
    side_t       dv_side_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [31:0] rem_in;
        logic [31:0] r_in;
        logic [32:0] q_in;
        side_t       side_in;
        logic [32:0] x;

        if (j == 0)
        begin : g_first
            // Dividend bits above the quotient range leave 2^29 behind.
            assign rem_in  = 32'h2000_0000;
            assign r_in    = sq_root_reg[SQRT_STEPS-1];
            assign q_in    = '0;
            assign side_in = sq_side_reg[SQRT_STEPS-1];
        end
        else
        begin : g_next
            assign rem_in  = dv_rem_reg[j-1];
            assign r_in    = dv_r_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
            assign side_in = dv_side_reg[j-1];
        end

        assign x = {rem_in, 1'b0};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (x >= {1'b0, r_in})
                begin
                    dv_rem_reg[j] <= 32'(x - {1'b0, r_in});
                    dv_q_reg[j]   <= {q_in[31:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg[j] <= x[31:0];
                    dv_q_reg[j]   <= {q_in[31:0], 1'b0};
                end
                dv_r_reg[j]    <= r_in;
                dv_side_reg[j] <= side_in;
            end
        end
    end

    // Scale each magnitude by the reciprocal, round, clamp and sign.
    logic        v1_v_reg, v2_v_reg;
    logic [63:0] v1_p_reg [3];
    side_t       v1_side_reg;
    ldq_vec_t    v2_vec_reg;
    ldq_vec_t    vec_next;
    logic [63:0] rnd;
    logic [31:0] vm;

    always_comb
    begin
        rnd = '0;
        vm  = '0;
        for (int i = 0; i < 3; i++)
        begin
            rnd = v1_p_reg[i] + (64'd1 << 31);
            vm  = rnd[63:32];
            if (vm > (32'd1 << VFRAC))
            begin
                vm = 32'd1 << VFRAC;
            end
            vec_next.v[i] = v1_side_reg.neg[i] ? -vm : vm;
        end
        vec_next.o     = v1_side_reg.o;
        vec_next.degen = v1_side_reg.degen;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v1_p_reg[i] <= 64'(dv_side_reg[DIV_STEPS-1].m[i]) * 64'(dv_q_reg[DIV_STEPS-1]);
            end
            v1_side_reg <= dv_side_reg[DIV_STEPS-1];
            v2_vec_reg  <= vec_next;
        end
    end

    // Valid bits along the whole chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            v1_v_reg <= 1'b0;
            v2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            sq_v_reg[0] <= s5_v_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                sq_v_reg[k] <= sq_v_reg[k-1];
            end
            dv_v_reg[0] <= sq_v_reg[SQRT_STEPS-1];
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                dv_v_reg[j] <= dv_v_reg[j-1];
            end
            v1_v_reg <= dv_v_reg[DIV_STEPS-1];
            v2_v_reg <= v1_v_reg;
        end
    end

    assign out_valid = v2_v_reg;
    assign out_vec   = v2_vec_reg;

endmodule

// File: hw/rtl/ldq_mul.sv
module ldq_mul
    import ldq_pkg::*;
(
    input  logic                clk,
    input  logic                adv,
    input  logic signed [63:0]  a,
    input  logic signed [63:0]  b,
    output logic signed [127:0] p
);

    logic         m1_neg_reg, m2_neg_reg, m3_neg_reg;
    logic [63:0]  m1_a_reg, m1_b_reg;
    logic [63:0]  m2_pp_reg [4];
    logic [127:0] m3_sum_reg;
    logic [127:0] m4_p_reg;

    // Magnitudes, four 32x32 partial products, their sum, then the sign.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_a_reg   <= a[63] ? 64'(-a) : 64'(a);
            m1_b_reg   <= b[63] ? 64'(-b) : 64'(b);
            m1_neg_reg <= a[63] ^ b[63];

            m2_pp_reg[0] <= 64'(m1_a_reg[31:0])  * 64'(m1_b_reg[31:0]);
            m2_pp_reg[1] <= 64'(m1_a_reg[31:0])  * 64'(m1_b_reg[63:32]);
            m2_pp_reg[2] <= 64'(m1_a_reg[63:32]) * 64'(m1_b_reg[31:0]);
            m2_pp_reg[3] <= 64'(m1_a_reg[63:32]) * 64'(m1_b_reg[63:32]);
            m2_neg_reg   <= m1_neg_reg;

            m3_sum_reg <= 128'(m2_pp_reg[0])
                        + (128'(m2_pp_reg[1]) << 32)
                        + (128'(m2_pp_reg[2]) << 32)
                        + (128'(m2_pp_reg[3]) << 64);
            m3_neg_reg <= m2_neg_reg;

            m4_p_reg <= m3_neg_reg ? -m3_sum_reg : m3_sum_reg;
        end
    end

    assign p = $signed(m4_p_reg);

endmodule

// File: hw/rtl/ldq_back.sv
module ldq_back
    import ldq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  ldq_vec_t                 in_vec,
    output logic                     out_valid,
    output logic signed [COEF_W-1:0] coef [10],
    output logic                     degenerate
);

    // Round off n fraction bits (ties upward) and saturate to 64 bits.
    function automatic logic [63:0] rnd_sat(input logic signed [127:0] x, input int n);
        logic signed [127:0] y;
        y = x;
        if (n > 0)
        begin
            y = (x + (128'sd1 <<< (n - 1))) >>> n;
        end
        if (y[127:63] == {65{y[127]}})
        begin
            return y[63:0];
        end
        return y[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    // Stage 1: direction products and origin projections.
    logic               b1_v_reg;
    ldq_vec_t           b1_vec_reg;
    logic signed [63:0] b1_qd_reg [3];
    logic signed [63:0] b1_qx_reg [3];
    logic signed [63:0] b1_ov_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_vec_reg <= in_vec;
            for (int i = 0; i < 3; i++)
            begin
                b1_qd_reg[i] <= 64'($signed(in_vec.v[i])) * 64'($signed(in_vec.v[i]));
                b1_ov_reg[i] <= 64'($signed(in_vec.o[i])) * 64'($signed(in_vec.v[i]));
            end
            b1_qx_reg[0] <= 64'($signed(in_vec.v[0])) * 64'($signed(in_vec.v[1]));
            b1_qx_reg[1] <= 64'($signed(in_vec.v[0])) * 64'($signed(in_vec.v[2]));
            b1_qx_reg[2] <= 64'($signed(in_vec.v[1])) * 64'($signed(in_vec.v[2]));
        end
    end

    // Stage 2: diagonal terms, the mixed factor and the rounded o.v.
    logic               b2_v_reg;
    ldq_vec_t           b2_vec_reg;
    logic signed [63:0] b2_om_reg [3];
    logic signed [63:0] b2_qx_reg [3];
    logic signed [63:0] b2_mm_reg;
    logic signed [35:0] b2_dov_reg;
    logic signed [65:0] acc;
    logic signed [65:0] dov_w;

    always_comb
    begin
        acc   = 66'(b1_ov_reg[0]) + 66'(b1_ov_reg[1]) + 66'(b1_ov_reg[2]);
        dov_w = (acc + (66'sd1 <<< (VFRAC - 1))) >>> VFRAC;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_vec_reg <= b1_vec_reg;
            for (int i = 0; i < 3; i++)
            begin
                b2_om_reg[i] <= (64'sd1 <<< UFRAC) - b1_qd_reg[i];
                b2_qx_reg[i] <= b1_qx_reg[i];
            end
            b2_mm_reg  <= b1_qd_reg[0] + b1_qd_reg[1] + b1_qd_reg[2] - (64'sd1 <<< (UFRAC + 1));
            b2_dov_reg <= dov_w[35:0];
        end
    end

    // Stage 3: projection times direction.
    logic               b3_v_reg;
    ldq_vec_t           b3_vec_reg;
    logic signed [63:0] b3_om_reg [3];
    logic signed [63:0] b3_qx_reg [3];
    logic signed [63:0] b3_mm_reg;
    logic signed [67:0] b3_dvp_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b3_vec_reg <= b2_vec_reg;
            for (int i = 0; i < 3; i++)
            begin
                b3_om_reg[i]  <= b2_om_reg[i];
                b3_qx_reg[i]  <= b2_qx_reg[i];
                b3_dvp_reg[i] <= 68'(b2_dov_reg) * 68'($signed(b2_vec_reg.v[i]));
            end
            b3_mm_reg <= b2_mm_reg;
        end
    end

    // Stage 4: offset vector from the origin to its foot on the line.
    logic               b4_v_reg;
    logic               b4_degen_reg;
    logic signed [63:0] b4_om_reg [3];
    logic signed [63:0] b4_qx_reg [3];
    logic signed [63:0] b4_mm_reg;
    logic signed [63:0] b4_dv_reg [3];
    logic signed [67:0] dvr [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dvr[i] = (b3_dvp_reg[i] + (68'sd1 <<< (VFRAC - 1))) >>> VFRAC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b4_degen_reg <= b3_vec_reg.degen;
            for (int i = 0; i < 3; i++)
            begin
                b4_om_reg[i] <= b3_om_reg[i];
                b4_qx_reg[i] <= b3_qx_reg[i];
                b4_dv_reg[i] <= 64'(dvr[i]) - 64'($signed(b3_vec_reg.o[i]));
            end
            b4_mm_reg <= b3_mm_reg;
        end
    end

    // Coefficient products, one pipelined multiplier per product.
    logic signed [63:0]  ma [NUM_MUL];
    logic signed [63:0]  mb [NUM_MUL];
    logic signed [127:0] mp [NUM_MUL];

    always_comb
    begin
        ma[0]  = b4_om_reg[0]; mb[0]  = b4_om_reg[0];
        ma[1]  = b4_om_reg[1]; mb[1]  = b4_om_reg[1];
        ma[2]  = b4_om_reg[2]; mb[2]  = b4_om_reg[2];
        ma[3]  = b4_qx_reg[0]; mb[3]  = b4_qx_reg[0];
        ma[4]  = b4_qx_reg[1]; mb[4]  = b4_qx_reg[1];
        ma[5]  = b4_qx_reg[2]; mb[5]  = b4_qx_reg[2];
        ma[6]  = b4_dv_reg[0]; mb[6]  = b4_dv_reg[0];
        ma[7]  = b4_dv_reg[1]; mb[7]  = b4_dv_reg[1];
        ma[8]  = b4_dv_reg[2]; mb[8]  = b4_dv_reg[2];
        ma[9]  = b4_qx_reg[0]; mb[9]  = b4_mm_reg;
        ma[10] = b4_qx_reg[1]; mb[10] = b4_mm_reg;
        ma[11] = b4_qx_reg[2]; mb[11] = b4_mm_reg;
        ma[12] = b4_om_reg[0]; mb[12] = b4_dv_reg[0];
        ma[13] = b4_qx_reg[0]; mb[13] = b4_dv_reg[1];
        ma[14] = b4_qx_reg[1]; mb[14] = b4_dv_reg[2];
        ma[15] = b4_om_reg[1]; mb[15] = b4_dv_reg[1];
        ma[16] = b4_qx_reg[0]; mb[16] = b4_dv_reg[0];
        ma[17] = b4_qx_reg[2]; mb[17] = b4_dv_reg[2];
        ma[18] = b4_om_reg[2]; mb[18] = b4_dv_reg[2];
        ma[19] = b4_qx_reg[1]; mb[19] = b4_dv_reg[0];
        ma[20] = b4_qx_reg[2]; mb[20] = b4_dv_reg[1];
    end

    for (genvar g = 0; g < NUM_MUL; g++)
    begin : g_mul
        ldq_mul u_mul
        (
            .clk (clk),
            .adv (adv),
            .a   (ma[g]),
            .b   (mb[g]),
            .p   (mp[g])
        );
    end

    logic md_v_reg   [MUL_STAGES];
    logic md_deg_reg [MUL_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            md_deg_reg[0] <= b4_degen_reg;
            for (int k = 1; k < MUL_STAGES; k++)
            begin
                md_deg_reg[k] <= md_deg_reg[k-1];
            end
        end
    end

    // Exact sums in stored coefficient order.
    logic                b9_v_reg;
    logic                b9_deg_reg;
    logic signed [127:0] b9_s_reg [10];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b9_deg_reg  <= md_deg_reg[MUL_STAGES-1];
            b9_s_reg[0] <= mp[0] + mp[3] + mp[4];
            b9_s_reg[1] <= mp[1] + mp[3] + mp[5];
            b9_s_reg[2] <= mp[2] + mp[4] + mp[5];
            b9_s_reg[3] <= mp[6] + mp[7] + mp[8];
            b9_s_reg[4] <= mp[9];
            b9_s_reg[5] <= mp[10];
            b9_s_reg[6] <= mp[12] - mp[13] - mp[14];
            b9_s_reg[7] <= mp[11];
            b9_s_reg[8] <= mp[15] - mp[16] - mp[17];
            b9_s_reg[9] <= mp[18] - mp[19] - mp[20];
        end
    end

    // Output register: rounding, saturation, degenerate override.
    logic                     b10_v_reg;
    logic                     b10_deg_reg;
    logic signed [COEF_W-1:0] b10_c_reg [10];
    logic [63:0]              c_next [10];

    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            if (i == 3)
            begin
                c_next[i] = rnd_sat(b9_s_reg[i], 2 * CFRAC - COEF_FRAC);
            end
            else if (i == 6 || i == 8 || i == 9)
            begin
                c_next[i] = rnd_sat(b9_s_reg[i], UFRAC + CFRAC - COEF_FRAC);
            end
            else
            begin
                c_next[i] = rnd_sat(b9_s_reg[i], 2 * UFRAC - COEF_FRAC);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b10_deg_reg <= b9_deg_reg;
            for (int i = 0; i < 10; i++)
            begin
                b10_c_reg[i] <= b9_deg_reg ? '0 : $signed(c_next[i]);
            end
        end
    end

    // Valid bits along the back stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
            for (int k = 0; k < MUL_STAGES; k++)
            begin
                md_v_reg[k] <= 1'b0;
            end
            b9_v_reg  <= 1'b0;
            b10_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_v_reg <= in_valid;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
            md_v_reg[0] <= b4_v_reg;
            for (int k = 1; k < MUL_STAGES; k++)
            begin
                md_v_reg[k] <= md_v_reg[k-1];
            end
            b9_v_reg  <= md_v_reg[MUL_STAGES-1];
            b10_v_reg <= b9_v_reg;
        end
    end

    assign out_valid  = b10_v_reg;
    assign degenerate = b10_deg_reg;
    assign coef       = b10_c_reg;

endmodule

// File: hw/rtl/line_distance_quadric_top.sv
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_stall    origin_x..z, through_x..z (Q16.16)
// output   out        out_valid / out_stall  ten coefficients (Q32.32), degenerate
//
// One transaction is accepted per cycle while in_stall is low; each line passes
// through the input register and queue, the normalizer front, the 32-stage square
// root, the 33-stage reciprocal, the scaling and the back pipeline.
// Reset clears only the valid bits and queue pointers; no clearing pass runs.
// A stall on the output freezes the arithmetic pipeline; the front keeps
// accepting until its four-entry queue fills, then raises in_stall.
module line_distance_quadric_top
    import ldq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] origin_z,
    input  logic signed [COORD_W-1:0] through_x,
    input  logic signed [COORD_W-1:0] through_y,
    input  logic signed [COORD_W-1:0] through_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COEF_W-1:0]  coef_xx,
    output logic signed [COEF_W-1:0]  coef_yy,
    output logic signed [COEF_W-1:0]  coef_zz,
    output logic signed [COEF_W-1:0]  constant_term,
    output logic signed [COEF_W-1:0]  half_xy,
    output logic signed [COEF_W-1:0]  half_xz,
    output logic signed [COEF_W-1:0]  half_x,
    output logic signed [COEF_W-1:0]  half_yz,
    output logic signed [COEF_W-1:0]  half_y,
    output logic signed [COEF_W-1:0]  half_z,
    output logic                      degenerate
);

    logic      push, q_full, q_empty, adv, n_valid;
    ldq_item_t f_item, q_head;
    ldq_vec_t  n_vec;
    logic signed [COEF_W-1:0] coef [10];

    // The whole arithmetic pipeline moves unless a finished result waits.
    assign adv = !(out_valid && out_stall);

    ldq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .origin_z  (origin_z),
        .through_x (through_x),
        .through_y (through_y),
        .through_z (through_z),
        .q_full    (q_full),
        .push      (push),
        .item      (f_item)
    );

    ldq_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (f_item),
        .pop       (adv),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    ldq_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (!q_empty),
        .in_item   (q_head),
        .out_valid (n_valid),
        .out_vec   (n_vec)
    );

    ldq_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (n_valid),
        .in_vec     (n_vec),
        .out_valid  (out_valid),
        .coef       (coef),
        .degenerate (degenerate)
    );

    assign coef_xx       = coef[0];
    assign coef_yy       = coef[1];
    assign coef_zz       = coef[2];
    assign constant_term = coef[3];
    assign half_xy       = coef[4];
    assign half_xz       = coef[5];
    assign half_x        = coef[6];
    assign half_yz       = coef[7];
    assign half_y        = coef[8];
    assign half_z        = coef[9];

endmodule

// File: hw/rtl/ldq_checker.sv
module ldq_checker
    import ldq_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [COEF_W-1:0]  coef_xx,
    input logic signed [COEF_W-1:0]  coef_yy,
    input logic signed [COEF_W-1:0]  constant_term,
    input logic signed [COEF_W-1:0]  half_x,
    input logic                      degenerate
);

    // A stalled input transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input withdrawn while stalled");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its coef_xx and half_x values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(coef_xx) && $stable(half_x))
        else $error("stalled result changed");

    // Coincident points give zero coef_xx, coef_yy, constant_term and half_x.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> coef_xx == 0 && coef_yy == 0
            && constant_term == 0 && half_x == 0)
        else $error("degenerate line with nonzero coefficients");

    // The coef_xx diagonal term and the constant term are never negative.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !coef_xx[COEF_W-1] && !constant_term[COEF_W-1])
        else $error("negative squared term");

endmodule

bind line_distance_quadric_top ldq_checker u_ldq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .coef_xx       (coef_xx),
    .coef_yy       (coef_yy),
    .constant_term (constant_term),
    .half_x        (half_x),
    .degenerate    (degenerate)
);

// File: test/tb_line_distance_quadric_top.sv
module tb_line_distance_quadric_top;
    import ldq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [COORD_W-1:0] o[3];
        logic signed [COORD_W-1:0] t[3];
    } line_t;

    typedef struct {
        logic signed [COEF_W-1:0] c[10];
        logic                     degen;
    } quad_t;

    localparam logic signed [63:0] COEF_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] COEF_MIN = 64'sh8000_0000_0000_0000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_PER_PHASE = 234;

    // Scoreboard: predicts the quadric of each accepted line and checks results in order.
    class quadric_scoreboard;
        quad_t pending[$];
        int    errors;
        int    lines_seen;
        int    results_seen;
        int    degenerate_seen;
        int    saturated_seen;

        function new();
            errors = 0;
            lines_seen = 0;
            results_seen = 0;
            degenerate_seen = 0;
            saturated_seen = 0;
        endfunction

        function wide_t mulw(input logic signed [63:0] a, input logic signed [63:0] b);
            wide_t x;
            wide_t y;
            x = a;
            y = b;
            return x * y;
        endfunction

        // Add half an LSB, then shift arithmetically, so ties round toward +infinity.
        function wide_t round_shift(input wide_t a, input int n);
            wide_t half;
            half = wide_t'(1) <<< (n - 1);
            return (a + half) >>> n;
        endfunction

        function logic signed [63:0] clip64(input wide_t a);
            wide_t hi;
            wide_t lo;
            hi = COEF_MAX;
            lo = COEF_MIN;
            if (a > hi)
                return COEF_MAX;
            if (a < lo)
                return COEF_MIN;
            return a[63:0];
        endfunction

        function logic signed [63:0] to_coef(input wide_t a, input int from);
            if (from > COEF_FRAC)
                return clip64(round_shift(a, from - COEF_FRAC));
            return clip64(a);
        endfunction

        function logic [63:0] int_sqrt(input logic [63:0] s_in);
            logic [63:0] s;
            logic [63:0] r;
            logic [63:0] b;
            s = s_in;
            r = 0;
            b = 64'd1 << 62;
            while (b > s)
                b = b >> 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function quad_t predict_quadric(input line_t ln);
            logic signed [63:0] o[3];
            logic signed [63:0] v[3];
            logic signed [63:0] dv[3];
            logic signed [63:0] om[3];
            logic signed [63:0] q[3][3];
            logic signed [63:0] mm;
            logic signed [63:0] dov;
            logic signed [63:0] d;
            logic [63:0]        mag[3];
            logic [63:0]        mx;
            logic [63:0]        s;
            logic [63:0]        r;
            logic [63:0]        rc;
            logic [63:0]        vm;
            logic               neg[3];
            wide_t              acc;
            quad_t              res;
            res.degen = 1'b0;
            for (int k = 0; k < 10; k++)
                res.c[k] = '0;
            for (int i = 0; i < 3; i++)
            begin
                o[i]   = ln.o[i];
                d      = 64'(ln.t[i]) - o[i];
                neg[i] = d < 0;
                mag[i] = neg[i] ? 64'(-d) : 64'(d);
            end
            if ((mag[0] | mag[1] | mag[2]) == 0)
            begin
                res.degen = 1'b1;
                return res;
            end

            // Scale the direction so that its largest magnitude lies in [2^30, 2^31).
            mx = mag[0];
            if (mag[1] > mx)
                mx = mag[1];
            if (mag[2] > mx)
                mx = mag[2];
            while (mx >= (64'd1 << 31))
            begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] >> 1;
            end
            while (mx < (64'd1 << 30))
            begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] << 1;
            end
            s  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            r  = int_sqrt(s);
            rc = (64'd1 << 62) / r;
            for (int i = 0; i < 3; i++)
            begin
                vm = (mag[i] * rc + (64'd1 << 31)) >> 32;
                if (vm > (64'd1 << VFRAC))
                    vm = 64'd1 << VFRAC;
                v[i] = neg[i] ? -$signed(vm) : $signed(vm);
            end

            // Exact products of the unit direction in Q.60.
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    q[i][j] = v[i] * v[j];
            for (int i = 0; i < 3; i++)
                om[i] = (64'sd1 <<< UFRAC) - q[i][i];
            mm = q[0][0] + q[1][1] + q[2][2] - (64'sd1 <<< (UFRAC + 1));

            // Offset of the origin from its projection onto the line.
            acc = mulw(o[0], v[0]) + mulw(o[1], v[1]) + mulw(o[2], v[2]);
            dov = clip64(round_shift(acc, VFRAC));
            for (int i = 0; i < 3; i++)
                dv[i] = clip64(round_shift(mulw(dov, v[i]), VFRAC)) - o[i];

            res.c[0] = to_coef(mulw(om[0], om[0]) + mulw(q[0][1], q[0][1])
                               + mulw(q[0][2], q[0][2]), 2 * UFRAC);
            res.c[1] = to_coef(mulw(om[1], om[1]) + mulw(q[0][1], q[0][1])
                               + mulw(q[1][2], q[1][2]), 2 * UFRAC);
            res.c[2] = to_coef(mulw(om[2], om[2]) + mulw(q[0][2], q[0][2])
                               + mulw(q[1][2], q[1][2]), 2 * UFRAC);
            res.c[3] = to_coef(mulw(dv[0], dv[0]) + mulw(dv[1], dv[1])
                               + mulw(dv[2], dv[2]), 2 * CFRAC);
            res.c[4] = to_coef(mulw(q[0][1], mm), 2 * UFRAC);
            res.c[5] = to_coef(mulw(q[0][2], mm), 2 * UFRAC);
            res.c[6] = to_coef(mulw(om[0], dv[0]) - mulw(q[0][1], dv[1])
                               - mulw(q[0][2], dv[2]), UFRAC + CFRAC);
            res.c[7] = to_coef(mulw(q[1][2], mm), 2 * UFRAC);
            res.c[8] = to_coef(mulw(om[1], dv[1]) - mulw(q[0][1], dv[0])
                               - mulw(q[1][2], dv[2]), UFRAC + CFRAC);
            res.c[9] = to_coef(mulw(om[2], dv[2]) - mulw(q[0][2], dv[0])
                               - mulw(q[1][2], dv[1]), UFRAC + CFRAC);
            return res;
        endfunction

        function void note_line(input line_t ln);
            quad_t e;
            e = predict_quadric(ln);
            lines_seen++;
            if (e.degen)
                degenerate_seen++;
            if (e.c[3] == COEF_MAX)
                saturated_seen++;
            pending.push_back(e);
        endfunction

        function void check_result(input quad_t got);
            string names[10];
            quad_t e;
            names = '{"coef_xx", "coef_yy", "coef_zz", "constant_term", "half_xy",
                      "half_xz", "half_x", "half_yz", "half_y", "half_z"};
            results_seen++;
            if (pending.size() == 0)
            begin
                $display("%t: unexpected result transaction", $realtime);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < 10; k++)
                if (got.c[k] !== e.c[k])
                begin
                    $display("%t: %s mismatch, expected %0d, actual %0d",
                             $realtime, names[k], e.c[k], got.c[k]);
                    errors++;
                end
            if (got.degen !== e.degen)
            begin
                $display("%t: degenerate mismatch, expected %0b, actual %0b",
                         $realtime, e.degen, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] through_x;
    logic signed [COORD_W-1:0] through_y;
    logic signed [COORD_W-1:0] through_z;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [COEF_W-1:0]  coef_xx;
    logic signed [COEF_W-1:0]  coef_yy;
    logic signed [COEF_W-1:0]  coef_zz;
    logic signed [COEF_W-1:0]  constant_term;
    logic signed [COEF_W-1:0]  half_xy;
    logic signed [COEF_W-1:0]  half_xz;
    logic signed [COEF_W-1:0]  half_x;
    logic signed [COEF_W-1:0]  half_yz;
    logic signed [COEF_W-1:0]  half_y;
    logic signed [COEF_W-1:0]  half_z;
    logic                      degenerate;

    quadric_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;

    line_distance_quadric_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .origin_z      (origin_z),
        .through_x     (through_x),
        .through_y     (through_y),
        .through_z     (through_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coef_xx       (coef_xx),
        .coef_yy       (coef_yy),
        .coef_zz       (coef_zz),
        .constant_term (constant_term),
        .half_xy       (half_xy),
        .half_xz       (half_xz),
        .half_x        (half_x),
        .half_yz       (half_yz),
        .half_y        (half_y),
        .half_z        (half_z),
        .degenerate    (degenerate)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Drive one line and hold it until the block accepts the transaction.
    task automatic send_line(input line_t ln);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        origin_x  = ln.o[0];
        origin_y  = ln.o[1];
        origin_z  = ln.o[2];
        through_x = ln.t[0];
        through_y = ln.t[1];
        through_z = ln.t[2];
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        board.note_line(ln);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_points(input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] oz, input logic [31:0] tx,
                               input logic [31:0] ty, input logic [31:0] tz);
        line_t ln;
        ln.o = '{ox, oy, oz};
        ln.t = '{tx, ty, tz};
        send_line(ln);
    endtask

    function automatic logic [31:0] rand_coord(input int kind);
        case (kind)
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
            2:       return 32'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // Random lines: mostly well-scaled geometry, with coincident and extreme cases mixed in.
    task automatic send_random_line();
        line_t ln;
        int    sel;
        int    kind;
        sel  = $urandom_range(0, 9);
        kind = $urandom_range(0, 9) < 4 ? 0 : ($urandom_range(0, 9) < 8 ? 1 : 3);
        for (int i = 0; i < 3; i++)
            ln.o[i] = rand_coord(kind);
        for (int i = 0; i < 3; i++)
        begin
            case (sel)
                0:       ln.t[i] = ln.o[i];
                1, 2:    ln.t[i] = ln.o[i] + rand_coord(2);
                3:       ln.t[i] = (i == $urandom_range(0, 2)) ? rand_coord(0) : ln.o[i];
                default: ln.t[i] = rand_coord(kind == 3 ? 0 : kind);
            endcase
        end
        send_line(ln);
    endtask

    // Output side: random stall at the falling edge, check at the rising edge.
    initial
    begin
        quad_t got;
        out_stall = 1'b1;
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(0, 99) < recv_idle_pct);
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.c = '{coef_xx, coef_yy, coef_zz, constant_term, half_xy,
                          half_xz, half_x, half_yz, half_y, half_z};
                got.degen = degenerate;
                board.check_result(got);
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%t: timeout with %0d results outstanding",
                         $realtime, board.pending.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed lines, three random phases, drain.
    initial
    begin
        board         = new();
        send_idle_pct = 17;
        recv_idle_pct = 86;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        origin_x      = '0;
        origin_y      = '0;
        origin_z      = '0;
        through_x     = '0;
        through_y     = '0;
        through_z     = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Coincident points.
        send_points(0, 0, 0, 0, 0, 0);
        send_points(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
        // Unit steps along each axis, then single-LSB steps: negative on x and y, positive on z.
        send_points(0, 0, 0, 32'h0001_0000, 0, 0);
        send_points(0, 0, 0, 0, 32'h0001_0000, 0);
        send_points(0, 0, 0, 0, 0, 32'h0001_0000);
        send_points(0, 0, 0, 32'hFFFF_FFFF, 0, 0);
        send_points(0, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_points(0, 0, 0, 0, 0, 32'h0000_0001);
        // Diagonals and the widest directions.
        send_points(0, 0, 0, 1, 1, 1);
        send_points(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_points(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_points(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF);
        // Far origins, where the constant term saturates.
        send_points(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
        send_points(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0001, 32'h8000_0000, 32'h8000_0000);
        send_points(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
        // Lines not through the origin, with mixed signs and rounding ties.
        send_points(32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000,
                    32'h0005_0000, 32'h0001_0000, 32'hFFFF_8000);
        send_points(32'h0000_8000, 32'h0000_8000, 0, 32'h0000_8000, 32'h0001_8000, 0);
        send_points(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                    32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);

        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_line();
        send_idle_pct = 86;
        recv_idle_pct = 17;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_line();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_line();

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d lines (%0d coincident, %0d with saturated constant term),",
                 board.lines_seen, board.degenerate_seen, board.saturated_seen);
        $display("checked %0d results under three idle patterns on both channels.",
                 board.results_seen);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ldq_pkg.sv
hw/rtl/ldq_front.sv
hw/rtl/ldq_queue.sv
hw/rtl/ldq_norm.sv
hw/rtl/ldq_mul.sv
hw/rtl/ldq_back.sv
hw/rtl/line_distance_quadric_top.sv
hw/rtl/ldq_checker.sv
test/tb_line_distance_quadric_top.sv
